>>> src/qfv_pkg.sv
package qfv_pkg;

  localparam int MAX_POINTS = 256;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Snapshot queue between the accumulator and the solver.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Last iteration indices of the shared sequential units.
  localparam int MUL_LAST  = 63;
  localparam int DIV_LAST  = 127;
  localparam int SQRT_LAST = 23;
  localparam int TERM_LAST = 5;
  localparam int DET_LAST  = 3;

  // Numerator scaling for each quotient.
  localparam int SHIFT_A  = 20;
  localparam int SHIFT_B  = 12;
  localparam int SHIFT_C  = 4;
  localparam int SHIFT_VX = 15;

  localparam int TAIL_LAST = 20;

  typedef struct packed {
    logic signed [11:0] x_value;
    logic signed [23:0] y_value;
    logic               last_point;
  } qfv_in_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] vertex_x;
    logic signed [31:0] sigma;
    logic [15:0]        tail_prob;
    logic               degenerate;
  } qfv_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic signed [19:0] s1;
    logic signed [31:0] s2;
    logic signed [43:0] s3;
    logic signed [55:0] s4;
    logic signed [31:0] t0;
    logic signed [43:0] t1;
    logic signed [55:0] t2;
  } qfv_sums_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qfv_qstat_t;

  typedef enum logic [2:0] {
    OP_N, OP_S1, OP_S2, OP_S3, OP_S4, OP_T0, OP_T1, OP_T2
  } qfv_opnd_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SETUP, BK_MUL1, BK_MID, BK_MUL2, BK_ACC, BK_DSET, BK_DIV,
    BK_DEND, BK_SQRT, BK_VMUL, BK_SIG, BK_TAIL, BK_OUT
  } qfv_bstate_t;

  typedef enum logic [1:0] {
    DV_A, DV_B, DV_C, DV_VX
  } qfv_dsel_t;

  // Cofactor expansion of the four determinants D, Da, Db, Dc. Each row is six
  // triple products with alternating signs, the first one added.
  localparam qfv_opnd_t TERM_OPS [0:3][0:5][0:2] = '{
    '{'{OP_S4, OP_S2, OP_N }, '{OP_S4, OP_S1, OP_S1}, '{OP_S3, OP_S1, OP_S2},
      '{OP_S3, OP_S3, OP_N }, '{OP_S2, OP_S3, OP_S1}, '{OP_S2, OP_S2, OP_S2}},
    '{'{OP_T2, OP_S2, OP_N }, '{OP_T2, OP_S1, OP_S1}, '{OP_T1, OP_S1, OP_S2},
      '{OP_T1, OP_S3, OP_N }, '{OP_T0, OP_S3, OP_S1}, '{OP_T0, OP_S2, OP_S2}},
    '{'{OP_S4, OP_T1, OP_N }, '{OP_S4, OP_T0, OP_S1}, '{OP_S3, OP_T0, OP_S2},
      '{OP_S3, OP_T2, OP_N }, '{OP_S2, OP_T2, OP_S1}, '{OP_S2, OP_T1, OP_S2}},
    '{'{OP_S4, OP_S2, OP_T0}, '{OP_S4, OP_S1, OP_T1}, '{OP_S3, OP_S1, OP_T2},
      '{OP_S3, OP_S3, OP_T0}, '{OP_S2, OP_S3, OP_T1}, '{OP_S2, OP_S2, OP_T2}}
  };

  // Upper normal tail at 0, 0.25, ..., 5.0 in Q0.16.
  localparam logic [15:0] TAIL_TABLE [0:TAIL_LAST] = '{
    16'd32768, 16'd26299, 16'd20220, 16'd14852, 16'd10398, 16'd6924, 16'd4378,
    16'd2625, 16'd1491, 16'd801, 16'd407, 16'd195, 16'd88, 16'd38, 16'd15,
    16'd6, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0
  };

endpackage

>>> src/qfv_front.sv
module qfv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  qfv_pkg::qfv_in_t   in_item,
  input  qfv_pkg::qfv_qstat_t qstat,
  output logic               snap_push,
  output qfv_pkg::qfv_sums_t snap
);
  import qfv_pkg::*;

  logic accept;

  logic               p1_vld_r, p1_last_r;
  logic signed [11:0] p1_x_r;
  logic signed [23:0] p1_y_r;
  logic [22:0]        p1_x2_r;
  logic signed [35:0] p1_xy_r;

  logic               p2_vld_r, p2_last_r;
  logic signed [11:0] p2_x_r;
  logic signed [23:0] p2_y_r;
  logic [22:0]        p2_x2_r;
  logic signed [35:0] p2_xy_r;
  logic signed [34:0] p2_x3_r;
  logic [45:0]        p2_x4_r;
  logic signed [46:0] p2_x2y_r;

  logic signed [23:0] x2_c;
  logic signed [35:0] xy_c;
  logic signed [34:0] x3_c;
  logic [45:0]        x4_c;
  logic signed [46:0] x2y_c;

  qfv_sums_t sums_r, sums_nxt, sums_add;
  logic      add_ok;
  logic [1:0]        pend;
  logic [QCNT_W:0]   credit;

  // A last point in flight needs a queue slot when it reaches the adder.
  always_comb begin
    pend   = 2'({1'b0, p1_vld_r & p1_last_r}) + 2'({1'b0, p2_vld_r & p2_last_r});
    credit = (QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(pend);
    full   = (credit >= (QCNT_W+1)'(QDEPTH));
    accept = push & ~full;
  end

  assign x2_c  = 24'(in_item.x_value) * 24'(in_item.x_value);
  assign xy_c  = 36'(in_item.x_value) * 36'(in_item.y_value);
  assign x3_c  = 35'($signed({1'b0, p1_x2_r})) * 35'(p1_x_r);
  assign x4_c  = 46'(p1_x2_r) * 46'(p1_x2_r);
  assign x2y_c = 47'($signed({1'b0, p1_x2_r})) * 47'(p1_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= accept;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_last_r <= accept & in_item.last_point;
    p1_x_r    <= in_item.x_value;
    p1_y_r    <= in_item.y_value;
    p1_x2_r   <= x2_c[22:0];
    p1_xy_r   <= xy_c;
    p2_last_r <= p1_last_r;
    p2_x_r    <= p1_x_r;
    p2_y_r    <= p1_y_r;
    p2_x2_r   <= p1_x2_r;
    p2_xy_r   <= p1_xy_r;
    p2_x3_r   <= x3_c;
    p2_x4_r   <= x4_c;
    p2_x2y_r  <= x2y_c;
  end

  always_comb begin
    add_ok      = p2_vld_r && (sums_r.n < CNT_W'(MAX_POINTS));
    sums_add.n  = sums_r.n + CNT_W'(1);
    sums_add.s1 = sums_r.s1 + 20'(p2_x_r);
    sums_add.s2 = sums_r.s2 + $signed(32'(p2_x2_r));
    sums_add.s3 = sums_r.s3 + 44'(p2_x3_r);
    sums_add.s4 = sums_r.s4 + $signed(56'(p2_x4_r));
    sums_add.t0 = sums_r.t0 + 32'(p2_y_r);
    sums_add.t1 = sums_r.t1 + 44'(p2_xy_r);
    sums_add.t2 = sums_r.t2 + 56'(p2_x2y_r);
    snap        = add_ok ? sums_add : sums_r;
    snap_push   = p2_vld_r & p2_last_r;
    sums_nxt    = snap_push ? '0 : snap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else begin
      sums_r <= sums_nxt;
    end
  end

endmodule

>>> src/qfv_fifo.sv
module qfv_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qfv_pkg::qfv_sums_t  wdata,
  input  logic                pop,
  output qfv_pkg::qfv_sums_t  rdata,
  output qfv_pkg::qfv_qstat_t qstat
);
  import qfv_pkg::*;

  qfv_sums_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign rdata       = mem_r[rptr_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.count = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/qfv_back.sv
module qfv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qfv_pkg::qfv_qstat_t qstat,
  input  qfv_pkg::qfv_sums_t  rdata,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output qfv_pkg::qfv_out_t   out_item
);
  import qfv_pkg::*;

  qfv_bstate_t state_r, state_nxt;
  qfv_sums_t   snap_r;

  logic [1:0]   det_idx_r;
  logic [2:0]   term_idx_r;
  logic [6:0]   cnt_r;
  logic [127:0] mcand_r, acc_r, detacc_r;
  logic [63:0]  mplier_r;
  logic         pneg_r;
  logic [127:0] dets_r [4];

  qfv_dsel_t    dsel_r;
  logic [127:0] dn_r, rem_r, dd_r;
  logic [31:0]  q_r;
  logic         qovf_r, qneg_r;

  logic signed [31:0] coef_a_r, coef_b_r, coef_c_r, vx_r, sg_r;
  logic [15:0]        tp_r;
  logic               degen_r;
  logic [47:0]        sqv_r, sqres_r, sqbit_r;
  logic signed [56:0] prod_r;

  qfv_out_t out_r;
  logic     out_vld_r;
  logic     out_load;

  function automatic logic signed [63:0] opnd_val(qfv_opnd_t c, qfv_sums_t s);
    logic signed [63:0] v;
    case (c)
      OP_N:    v = $signed(64'(s.n));
      OP_S1:   v = 64'(s.s1);
      OP_S2:   v = 64'(s.s2);
      OP_S3:   v = 64'(s.s3);
      OP_S4:   v = 64'(s.s4);
      OP_T0:   v = 64'(s.t0);
      OP_T1:   v = 64'(s.t1);
      OP_T2:   v = 64'(s.t2);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [31:0] qsat(logic [31:0] q, logic ovf, logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - q;
    end else begin
      r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  // Current triple product operands.
  logic signed [63:0] vp, vq, vr;
  logic [127:0]       acc_step, prod_val, det_sum;

  always_comb begin
    vp       = opnd_val(TERM_OPS[det_idx_r][term_idx_r][0], snap_r);
    vq       = opnd_val(TERM_OPS[det_idx_r][term_idx_r][1], snap_r);
    vr       = opnd_val(TERM_OPS[det_idx_r][term_idx_r][2], snap_r);
    acc_step = acc_r + (mplier_r[0] ? mcand_r : 128'd0);
    prod_val = pneg_r ? 128'd0 - acc_r : acc_r;
    det_sum  = term_idx_r[0] ? detacc_r - prod_val : detacc_r + prod_val;
  end

  // Divider operand setup and one restoring step.
  logic [127:0] dnum, dden, dnum_mag, dden_mag, dnum_sh, rem_sh, rem_sub;
  logic         rem_ge;

  always_comb begin
    if (dsel_r == DV_VX) begin
      dnum = 128'd0 - 128'($signed(coef_b_r));
      dden = 128'($signed(coef_a_r));
    end else begin
      dnum = dets_r[2'(dsel_r) + 2'd1];
      dden = dets_r[0];
    end
    dnum_mag = dnum[127] ? 128'd0 - dnum : dnum;
    dden_mag = dden[127] ? 128'd0 - dden : dden;
    case (dsel_r)
      DV_A:    dnum_sh = dnum_mag << SHIFT_A;
      DV_B:    dnum_sh = dnum_mag << SHIFT_B;
      DV_C:    dnum_sh = dnum_mag << SHIFT_C;
      default: dnum_sh = dnum_mag << SHIFT_VX;
    endcase
    rem_sh  = {rem_r[126:0], dn_r[127]};
    rem_ge  = (rem_sh >= dd_r);
    rem_sub = rem_sh - dd_r;
  end

  // Square root step, sigma scaling and the tail lookup.
  logic [48:0]        sq_trial;
  logic               sq_ge;
  logic signed [56:0] sg_adj, sg_shr;
  logic signed [31:0] sg_c;
  logic [32:0]        tmag;
  logic               in_tab;
  logic [4:0]         tidx;
  logic [15:0]        t_hi, t_lo, t_diff, t_v;
  logic [29:0]        t_prod;
  logic [16:0]        t_val, t_neg;
  logic [15:0]        tail_c;

  always_comb begin
    sq_trial = {1'b0, sqres_r} + {1'b0, sqbit_r};
    sq_ge    = ({1'b0, sqv_r} >= sq_trial);

    // Division by 2^16 truncates toward zero.
    sg_adj = prod_r[56] ? prod_r + 57'sd65535 : prod_r;
    sg_shr = sg_adj >>> 16;
    if (sg_shr > 57'sd2147483647) begin
      sg_c = 32'sh7FFF_FFFF;
    end else if (sg_shr < -57'sd2147483648) begin
      sg_c = 32'sh8000_0000;
    end else begin
      sg_c = sg_shr[31:0];
    end

    tmag   = sg_r[31] ? 33'd0 - {sg_r[31], sg_r} : {1'b0, sg_r};
    in_tab = (tmag[32:14] < 19'(TAIL_LAST));
    tidx   = in_tab ? tmag[18:14] : 5'd0;
    t_hi   = TAIL_TABLE[tidx];
    t_lo   = TAIL_TABLE[tidx + 5'd1];
    t_diff = t_hi - t_lo;
    t_prod = 30'(t_diff) * 30'(tmag[13:0]);
    t_v    = t_hi - t_prod[29:14];
    t_val  = in_tab ? {1'b0, t_v} : 17'd0;
    t_neg  = 17'd65536 - t_val;
    if (!sg_r[31]) begin
      tail_c = t_val[15:0];
    end else if (t_neg[16]) begin
      tail_c = 16'hFFFF;
    end else begin
      tail_c = t_neg[15:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!qstat.empty) state_nxt = BK_SETUP;
      BK_SETUP: state_nxt = BK_MUL1;
      BK_MUL1:  if (cnt_r == 7'(MUL_LAST)) state_nxt = BK_MID;
      BK_MID:   state_nxt = BK_MUL2;
      BK_MUL2:  if (cnt_r == 7'(MUL_LAST)) state_nxt = BK_ACC;
      BK_ACC: begin
        if (term_idx_r != 3'(TERM_LAST)) begin
          state_nxt = BK_SETUP;
        end else if (det_idx_r == 2'd0 && det_sum == 128'd0) begin
          state_nxt = BK_OUT;
        end else if (det_idx_r != 2'(DET_LAST)) begin
          state_nxt = BK_SETUP;
        end else begin
          state_nxt = BK_DSET;
        end
      end
      BK_DSET:  state_nxt = BK_DIV;
      BK_DIV:   if (cnt_r == 7'(DIV_LAST)) state_nxt = BK_DEND;
      BK_DEND: begin
        if (dsel_r == DV_A || dsel_r == DV_B) begin
          state_nxt = BK_DSET;
        end else if (dsel_r == DV_C) begin
          state_nxt = (coef_a_r > 32'sd0) ? BK_DSET : BK_OUT;
        end else begin
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT:  if (cnt_r == 7'(SQRT_LAST)) state_nxt = BK_VMUL;
      BK_VMUL:  state_nxt = BK_SIG;
      BK_SIG:   state_nxt = BK_TAIL;
      BK_TAIL:  state_nxt = BK_OUT;
      BK_OUT:   if (out_load) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop    = (state_r == BK_IDLE) && !qstat.empty;
    out_load = (state_r == BK_OUT) && (!out_vld_r || pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_load | (out_vld_r & ~pop);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          snap_r     <= rdata;
          det_idx_r  <= 2'd0;
          term_idx_r <= 3'd0;
          detacc_r   <= '0;
          dsel_r     <= DV_A;
          coef_a_r   <= '0;
          coef_b_r   <= '0;
          coef_c_r   <= '0;
          vx_r       <= '0;
          sg_r       <= '0;
          tp_r       <= '0;
          degen_r    <= 1'b1;
        end
      end
      BK_SETUP: begin
        mcand_r  <= {64'd0, mag64(vp)};
        mplier_r <= mag64(vq);
        acc_r    <= '0;
        cnt_r    <= '0;
        pneg_r   <= vp[63] ^ vq[63] ^ vr[63];
      end
      BK_MUL1, BK_MUL2: begin
        acc_r    <= acc_step;
        mcand_r  <= {mcand_r[126:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[63:1]};
        cnt_r    <= cnt_r + 7'd1;
      end
      BK_MID: begin
        mcand_r  <= acc_r;
        mplier_r <= mag64(vr);
        acc_r    <= '0;
        cnt_r    <= '0;
      end
      BK_ACC: begin
        if (term_idx_r == 3'(TERM_LAST)) begin
          dets_r[det_idx_r] <= det_sum;
          detacc_r          <= '0;
          term_idx_r        <= 3'd0;
          det_idx_r         <= det_idx_r + 2'd1;
        end else begin
          detacc_r   <= det_sum;
          term_idx_r <= term_idx_r + 3'd1;
        end
      end
      BK_DSET: begin
        dn_r   <= dnum_sh;
        dd_r   <= dden_mag;
        qneg_r <= dnum[127] ^ dden[127];
        rem_r  <= '0;
        q_r    <= '0;
        qovf_r <= 1'b0;
        cnt_r  <= '0;
      end
      BK_DIV: begin
        rem_r  <= rem_ge ? rem_sub : rem_sh;
        dn_r   <= {dn_r[126:0], 1'b0};
        q_r    <= {q_r[30:0], rem_ge};
        qovf_r <= qovf_r | q_r[31];
        cnt_r  <= cnt_r + 7'd1;
      end
      BK_DEND: begin
        case (dsel_r)
          DV_A:    coef_a_r <= qsat(q_r, qovf_r, qneg_r);
          DV_B:    coef_b_r <= qsat(q_r, qovf_r, qneg_r);
          DV_C:    coef_c_r <= qsat(q_r, qovf_r, qneg_r);
          default: vx_r     <= qsat(q_r, qovf_r, qneg_r);
        endcase
        dsel_r  <= qfv_dsel_t'(2'(dsel_r) + 2'd1);
        sqv_r   <= {coef_a_r[30:0], 17'd0};
        sqres_r <= '0;
        sqbit_r <= 48'd1 << 46;
        cnt_r   <= '0;
        if (dsel_r == DV_VX) begin
          degen_r <= 1'b0;
        end
      end
      BK_SQRT: begin
        if (sq_ge) begin
          sqv_r   <= sqv_r - sq_trial[47:0];
          sqres_r <= (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_r <= sqres_r >> 1;
        end
        sqbit_r <= sqbit_r >> 2;
        cnt_r   <= cnt_r + 7'd1;
      end
      BK_VMUL: prod_r <= 57'(vx_r) * 57'($signed({1'b0, sqres_r[23:0]}));
      BK_SIG:  sg_r   <= sg_c;
      BK_TAIL: tp_r   <= tail_c;
      BK_OUT: begin
        if (out_load) begin
          out_r.coef_a     <= coef_a_r;
          out_r.coef_b     <= coef_b_r;
          out_r.coef_c     <= coef_c_r;
          out_r.vertex_x   <= vx_r;
          out_r.sigma      <= sg_r;
          out_r.tail_prob  <= tp_r;
          out_r.degenerate <= degen_r;
        end
      end
      default: ;
    endcase
  end

  assign empty    = ~out_vld_r;
  assign out_item = out_r;

endmodule

>>> src/quadratic_fit_vertex_tail_prob.sv
// Channel   Direction  Handshake         Payload
// input     in         push / full       in_item  (x_value, y_value, last_point)
// result    out        pop / empty       out_item (a, b, c, vertex, sigma, tail, flag)
//
// Points are taken one per cycle while full is low; a three-stage multiply
// and add pipeline folds them into the power sums. Each last point hands a
// snapshot of the sums to a four-entry queue. The solver works one group at
// a time: up to 24 triple products on a bit-serial multiplier, up to four
// 128-step divisions, and for a > 0 a 24-step root, vertex, sigma and tail.
// Reset clears the sums, the queue and the result valid flag. Points keep
// flowing while the solver is busy; full rises only when the queue has no room
// for another group, and a waiting result holds the solver until it is popped.
module quadratic_fit_vertex_tail_prob (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  qfv_pkg::qfv_in_t  in_item,
  input  logic              pop,
  output logic              empty,
  output qfv_pkg::qfv_out_t out_item
);
  import qfv_pkg::*;

  qfv_qstat_t qstat;
  qfv_sums_t  snap, rdata;
  logic       snap_push, q_pop;

  qfv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .qstat     (qstat),
    .snap_push (snap_push),
    .snap      (snap)
  );

  qfv_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (snap_push),
    .wdata (snap),
    .pop   (q_pop),
    .rdata (rdata),
    .qstat (qstat)
  );

  qfv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .rdata    (rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

>>> src/qfv_checker.sv
module qfv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              push,
  input logic              full,
  input qfv_pkg::qfv_in_t  in_item,
  input logic              pop,
  input logic              empty,
  input qfv_pkg::qfv_out_t out_item
);
  import qfv_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed before transfer");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.degenerate |->
      out_item.vertex_x == 32'sd0 && out_item.sigma == 32'sd0 &&
      out_item.tail_prob == 16'd0)
    else $error("degenerate fit carries a vertex or tail");

  a_good_a: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_item.degenerate |-> out_item.coef_a > 32'sd0)
    else $error("fit flagged good with non-positive a");

  a_tail_half: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_item.degenerate && !out_item.sigma[31] |->
      out_item.tail_prob <= 16'd32768)
    else $error("tail above one half for non-negative sigma");

endmodule

bind quadratic_fit_vertex_tail_prob qfv_checker u_qfv_checker (.*);

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qfv_pkg::*;

  typedef logic signed [191:0] wide_t;

  localparam int GROUP_CAP = 256;
  localparam int unsigned NORMAL_TAIL [0:20] = '{
    32768, 26299, 20220, 14852, 10398, 6924, 4378, 2625, 1491, 801,
    407, 195, 88, 38, 15, 6, 2, 1, 0, 0, 0
  };

  class quad_fit_checker;
    int        npts;
    longint    sx, sxx, sxxx, sxxxx, sy, sxy, sxxy;
    qfv_out_t  pending_fits[$];
    int        errors, fits_seen, degen_seen, overflow_groups;

    function new();
      clear_sums();
      errors = 0;
      fits_seen = 0;
      degen_seen = 0;
      overflow_groups = 0;
    endfunction

    function void clear_sums();
      npts = 0;
      sx = 0; sxx = 0; sxxx = 0; sxxxx = 0;
      sy = 0; sxy = 0; sxxy = 0;
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] scaled_quot(wide_t num, int k, wide_t den);
      logic  neg;
      wide_t nm, dm, q;
      neg = (num < 0) != (den < 0);
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      q = (nm <<< k) / dm;
      if (neg) begin
        if (q > 192'sd2147483648) return 32'sh80000000;
        return -q[31:0];
      end
      if (q > 192'sd2147483647) return 32'sh7fffffff;
      return q[31:0];
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic [15:0] upper_tail(logic signed [31:0] s);
      longint m, idx, frac, v;
      m = (s < 0) ? -longint'(s) : longint'(s);
      idx = m >> 14;
      frac = m & 16383;
      if (idx >= 20) v = 0;
      else v = NORMAL_TAIL[idx] -
               (((NORMAL_TAIL[idx] - NORMAL_TAIL[idx + 1]) * frac) >> 14);
      if (s < 0) begin
        v = 65536 - v;
        if (v > 65535) v = 65535;
      end
      return v[15:0];
    endfunction

    // Exact Cramer solve over the power sums, as the block should do it.
    function qfv_out_t solve_group();
      qfv_out_t r;
      wide_t n, s1, s2, s3, s4, t0, t1, t2, d, da, db, dc;
      longint unsigned root;
      r = '0;
      r.degenerate = 1'b1;
      n = npts; s1 = sx; s2 = sxx; s3 = sxxx; s4 = sxxxx;
      t0 = sy; t1 = sxy; t2 = sxxy;
      d  = s4*s2*n - s4*s1*s1 + s3*s1*s2 - s3*s3*n + s2*s3*s1 - s2*s2*s2;
      if (d != 0) begin
        da = t2*s2*n - t2*s1*s1 + t1*s1*s2 - t1*s3*n + t0*s3*s1 - t0*s2*s2;
        db = s4*t1*n - s4*t0*s1 + s3*t0*s2 - s3*t2*n + s2*t2*s1 - s2*t1*s2;
        dc = s4*s2*t0 - s4*s1*t1 + s3*s1*t2 - s3*s3*t0 + s2*s3*t1 - s2*s2*t2;
        r.coef_a = scaled_quot(da, SHIFT_A, d);
        r.coef_b = scaled_quot(db, SHIFT_B, d);
        r.coef_c = scaled_quot(dc, SHIFT_C, d);
        if (r.coef_a > 0) begin
          root = floor_sqrt(longint'(r.coef_a) << 17);
          r.degenerate = 1'b0;
          r.vertex_x = clip32((-(longint'(r.coef_b) * 32768)) / longint'(r.coef_a));
          r.sigma = clip32((longint'(r.vertex_x) * longint'(root)) / 65536);
          r.tail_prob = upper_tail(r.sigma);
        end
      end
      return r;
    endfunction

    function void take_point(qfv_in_t p);
      longint x, y;
      x = p.x_value;
      y = p.y_value;
      if (npts < GROUP_CAP) begin
        npts++;
        sx += x; sxx += x*x; sxxx += x*x*x; sxxxx += x*x*x*x;
        sy += y; sxy += x*y; sxxy += x*x*y;
      end else if (npts == GROUP_CAP) begin
        overflow_groups++;
        npts++;
      end
      if (p.last_point) begin
        if (npts > GROUP_CAP) npts = GROUP_CAP;
        pending_fits.insert(pending_fits.size(), solve_group());
        clear_sums();
      end
    endfunction

    function void check_fit(qfv_out_t got);
      qfv_out_t exp_r;
      if (pending_fits.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending_fits.pop_front();
      fits_seen++;
      if (got.degenerate) degen_seen++;
      if (got.coef_a !== exp_r.coef_a)
        $display("%0t: coef_a exp %0d got %0d", $realtime, exp_r.coef_a, got.coef_a);
      if (got.coef_b !== exp_r.coef_b)
        $display("%0t: coef_b exp %0d got %0d", $realtime, exp_r.coef_b, got.coef_b);
      if (got.coef_c !== exp_r.coef_c)
        $display("%0t: coef_c exp %0d got %0d", $realtime, exp_r.coef_c, got.coef_c);
      if (got.vertex_x !== exp_r.vertex_x)
        $display("%0t: vertex_x exp %0d got %0d", $realtime, exp_r.vertex_x,
                 got.vertex_x);
      if (got.sigma !== exp_r.sigma)
        $display("%0t: sigma exp %0d got %0d", $realtime, exp_r.sigma, got.sigma);
      if (got.tail_prob !== exp_r.tail_prob)
        $display("%0t: tail_prob exp %0d got %0d", $realtime, exp_r.tail_prob,
                 got.tail_prob);
      if (got.degenerate !== exp_r.degenerate)
        $display("%0t: degenerate exp %0b got %0b", $realtime, exp_r.degenerate,
                 got.degenerate);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic     clk, rst_n, push, full, pop, empty;
  qfv_in_t  in_item;
  qfv_out_t out_item;

  quad_fit_checker fits = new();
  int  idle_pct, stall_pct, points_sent;
  bit  hold_pop;

  quadratic_fit_vertex_tail_prob dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .pop(pop), .empty(empty), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check each transfer and decide whether to stall next cycle.
  initial begin
    pop <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) fits.check_fit(out_item);
      pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_point(logic signed [11:0] x, logic signed [23:0] y, logic last);
    qfv_in_t p;
    p.x_value = x;
    p.y_value = y;
    p.last_point = last;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= p;
    do @(posedge clk); while (full);
    fits.take_point(p);
    points_sent++;
  endtask

  // Noisy parabola around vertex xv with curvature k, clamped to the y range.
  task automatic parabola_group(int size, int xv, int k, int c0, int spread);
    longint x, y;
    for (int i = 0; i < size; i++) begin
      x = longint'($urandom_range(2 * spread)) - spread + xv;
      if (x > 2047) x = 2047;
      if (x < -2048) x = -2048;
      y = ((longint'(k) * (x - xv) * (x - xv)) >>> 8) + c0 +
          $signed($urandom_range(127)) - 64;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      send_point(12'(x), 24'(y), i == size - 1);
    end
  endtask

  task automatic random_group();
    int kind, size;
    kind = $urandom_range(99);
    size = $urandom_range(3, 12);
    if (kind < 65) begin
      parabola_group(size, $signed($urandom_range(4095)) - 2048,
                     ($urandom_range(9) < 2) ? -$signed($urandom_range(1, 64))
                                             : $urandom_range(1, 64),
                     $signed($urandom_range(2097151)) - 1048576,
                     $urandom_range(16, 2048));
    end else if (kind < 85) begin
      for (int i = 0; i < size; i++)
        send_point(12'($urandom), 24'($urandom), i == size - 1);
    end else if (kind < 95) begin
      // Too few distinct abscissas for a solution.
      for (int i = 0; i < size; i++)
        send_point((i % 2) ? 12'sd300 : -12'sd5, 24'($urandom), i == size - 1);
    end else begin
      send_point(12'($urandom), 24'($urandom), 1'b1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (fits.pending_fits.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_item <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_pop = 1'b0;
    points_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed groups: field extremes, too few abscissas, concave data,
    // symmetric fit, vertices far on either side.
    send_point(-12'sd2048, -24'sd8388608, 1'b1);
    send_point(12'sd2047, 24'sd8388607, 1'b0);
    send_point(12'sd2047, 24'sd0, 1'b1);
    send_point(-12'sd256, 24'sd4096, 1'b0);
    send_point(12'sd0, 24'sd0, 1'b0);
    send_point(12'sd256, 24'sd4096, 1'b1);
    send_point(-12'sd256, -24'sd4096, 1'b0);
    send_point(12'sd0, 24'sd0, 1'b0);
    send_point(12'sd256, -24'sd4096, 1'b1);
    parabola_group(4, 2047, 64, 0, 1024);
    parabola_group(4, -2048, 64, 0, 1024);
    parabola_group(4, 40, 2, -1000, 200);
    send_point(12'sd2047, 24'sd8388607, 1'b0);
    send_point(-12'sd2048, 24'sd8388607, 1'b0);
    send_point(12'sd0, -24'sd8388608, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 58 : (phase == 3) ? 21 : 0;
      stall_pct = (phase == 2) ? 58 : (phase == 3) ? 21 : 0;
      if (phase == 1) begin
        // Receiver holds off for a long stretch while groups keep coming.
        fork
          begin
            hold_pop = 1'b1;
            repeat (30000) @(posedge clk);
            hold_pop = 1'b0;
          end
        join_none
        for (int g = 0; g < 10; g++)
          parabola_group(3, $signed($urandom_range(4095)) - 2048,
                         $urandom_range(1, 64), 0, 512);
      end
      if (phase == 2)
        parabola_group($urandom_range(257, 290), $signed($urandom_range(1023)) - 512,
                       $urandom_range(1, 8), 0, 1500);
      for (int base = points_sent; points_sent < base + 70; )
        random_group();
      wait_drained();
    end

    $display("Fitted %0d groups, %0d degenerate, %0d over the point cap, %0d points.",
             fits.fits_seen, fits.degen_seen, fits.overflow_groups, points_sent);
    if (fits.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
